>>> hw/rtl/slc_pkg.sv
// Shared types, geometry constants and helpers for the set-associative LRU write-back cache.
// Depends on nothing; every other file in hw/rtl imports it.
package slc_pkg;

  localparam int unsigned SETS       = 128;
  localparam int unsigned WAYS       = 4;
  localparam int unsigned LINE_BYTES = 64;
  localparam int unsigned ADDR_BITS  = 30;
  localparam int unsigned CNT_BITS   = 32;

  localparam int unsigned OFS_BITS = $clog2(LINE_BYTES);
  localparam int unsigned IDX_BITS = $clog2(SETS);
  localparam int unsigned WAY_BITS = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int unsigned TAG_BITS = ADDR_BITS - OFS_BITS - IDX_BITS;

  typedef logic [ADDR_BITS-1:0] addr_t;
  typedef logic [IDX_BITS-1:0]  set_idx_t;
  typedef logic [WAY_BITS-1:0]  way_t;
  typedef logic [TAG_BITS-1:0]  tag_t;
  typedef logic [CNT_BITS-1:0]  count_t;

  typedef struct packed {
    logic [WAYS-1:0]              valid;
    logic [WAYS-1:0]              dirty;
    logic [WAYS-1:0][WAY_BITS-1:0] rank;
  } set_meta_t;

  typedef struct packed {
    logic      en;
    set_idx_t  set;
    set_meta_t meta;
  } meta_wr_t;

  // Controls for the tag scan unit.
  typedef struct packed {
    logic     start;    // begin a scan of set/tag below
    logic     scan;     // a compare cycle is under way
    logic     advance;  // move on to the next way
    set_idx_t set;
    tag_t     tag;
  } scan_ctrl_t;

  typedef struct packed {
    logic match;
    logic last;
    way_t way;
  } scan_stat_t;

  typedef struct packed {
    logic     en;
    set_idx_t set;
    way_t     way;
    tag_t     tag;
  } tag_wr_t;

  // Metadata of a set that was never written: nothing valid, rank equals way index.
  function automatic set_meta_t reset_meta();
    set_meta_t m;
    m.valid = '0;
    m.dirty = '0;
    for (int i = 0; i < int'(WAYS); i++) begin
      m.rank[i] = WAY_BITS'(i);
    end
    return m;
  endfunction

endpackage

>>> hw/rtl/set_assoc_lru_writeback_cache.sv
// Top level of the set-associative LRU write-back cache tag model: sequencer,
// replacement and counters. Depends on slc_pkg, slc_meta_store and slc_tag_scan.
//
//  Channel  Handshake                Word
//  -------  -----------------------  ----------------------------------------------
//  request  in_valid_i / in_ready_o  address_i, is_write_i
//  result   out_valid_o/out_ready_i  hit_o, fill_*_o, writeback_*_o, *_so_far_o
//
// A request reads the set, then compares the tag of one way at a time on the single
// comparator until a hit or the last way (1..WAYS ways compared), then updates.
// Reset clears valid, dirty and recency state at once through per-set init bits.
// A new request is taken while a result waits; the update stalls only if the
// previous result has still not been taken.
module set_assoc_lru_writeback_cache
  import slc_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [ADDR_BITS-1:0] address_i,
  input  logic                 is_write_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic                 hit_o,
  output logic                 fill_valid_o,
  output logic [ADDR_BITS-1:0] fill_address_o,
  output logic                 writeback_valid_o,
  output logic [ADDR_BITS-1:0] writeback_address_o,
  output logic [CNT_BITS-1:0]  hits_so_far_o,
  output logic [CNT_BITS-1:0]  misses_so_far_o
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_CMP  = 3'b010,
    S_UPD  = 3'b100
  } state_e;

  state_e     state_q, state_d;
  addr_t      addr_q;
  logic       wr_q;
  logic       hit_q;
  way_t       hit_way_q;
  count_t     hits_q, misses_q;

  logic       accept;
  logic       upd_fire;
  scan_ctrl_t scan_ctrl;
  scan_stat_t scan_stat;
  set_meta_t  meta, meta_new;
  meta_wr_t   meta_wr;
  tag_wr_t    tag_wr;
  way_t       victim, way_sel;
  tag_t       victim_tag;
  logic       found_inv;
  way_t       old_rank;
  set_idx_t   req_set;
  tag_t       req_tag;

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign upd_fire   = (state_q == S_UPD) && (!out_valid_o || out_ready_i);

  assign req_set = addr_q[OFS_BITS +: IDX_BITS];
  assign req_tag = addr_q[OFS_BITS + IDX_BITS +: TAG_BITS];

  always_comb begin
    scan_ctrl.start   = accept;
    scan_ctrl.scan    = (state_q == S_CMP);
    scan_ctrl.advance = (state_q == S_CMP) && !scan_stat.match && !scan_stat.last;
    scan_ctrl.set     = address_i[OFS_BITS +: IDX_BITS];
    scan_ctrl.tag     = address_i[OFS_BITS + IDX_BITS +: TAG_BITS];
  end

  slc_meta_store u_meta (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .rd_en_i  (accept),
    .rd_set_i (address_i[OFS_BITS +: IDX_BITS]),
    .wr_i     (meta_wr),
    .meta_o   (meta)
  );

  slc_tag_scan u_scan (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (scan_ctrl),
    .valid_i   (meta.valid),
    .wr_i      (tag_wr),
    .sel_way_i (victim),
    .stat_o    (scan_stat),
    .sel_tag_o (victim_tag)
  );

  // Victim: lowest invalid way, otherwise the least recent one.
  always_comb begin
    found_inv = 1'b0;
    victim    = '0;
    for (int i = 0; i < int'(WAYS); i++) begin
      if (!found_inv && !meta.valid[i]) begin
        found_inv = 1'b1;
        victim    = WAY_BITS'(i);
      end
    end
    if (!found_inv) begin
      for (int i = 1; i < int'(WAYS); i++) begin
        if (meta.rank[i] < meta.rank[victim]) begin
          victim = WAY_BITS'(i);
        end
      end
    end
  end

  assign way_sel = hit_q ? hit_way_q : victim;

  // Move the chosen way to most recent; ranks above its old rank shift down.
  always_comb begin
    meta_new = meta;
    old_rank = meta.rank[way_sel];
    for (int i = 0; i < int'(WAYS); i++) begin
      if (meta.rank[i] > old_rank) begin
        meta_new.rank[i] = WAY_BITS'(meta.rank[i] - WAY_BITS'(1));
      end
    end
    meta_new.rank[way_sel] = WAY_BITS'(WAYS - 1);
    if (hit_q) begin
      meta_new.dirty[way_sel] = meta.dirty[way_sel] | wr_q;
    end else begin
      meta_new.valid[way_sel] = 1'b1;
      meta_new.dirty[way_sel] = wr_q;
    end
  end

  always_comb begin
    meta_wr.en   = upd_fire;
    meta_wr.set  = req_set;
    meta_wr.meta = meta_new;
    tag_wr.en    = upd_fire && !hit_q;
    tag_wr.set   = req_set;
    tag_wr.way   = victim;
    tag_wr.tag   = req_tag;
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = S_CMP;
        end
      end
      S_CMP: begin
        if (scan_stat.match || scan_stat.last) begin
          state_d = S_UPD;
        end
      end
      S_UPD: begin
        if (upd_fire) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      hit_q       <= 1'b0;
      hit_way_q   <= '0;
      hits_q      <= '0;
      misses_q    <= '0;
      out_valid_o <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == S_CMP) begin
        hit_q     <= scan_stat.match;
        hit_way_q <= scan_stat.way;
      end
      if (upd_fire) begin
        out_valid_o <= 1'b1;
        if (hit_q) begin
          if (hits_q != '1) begin
            hits_q <= CNT_BITS'(hits_q + CNT_BITS'(1));
          end
        end else if (misses_q != '1) begin
          misses_q <= CNT_BITS'(misses_q + CNT_BITS'(1));
        end
      end else if (out_ready_i) begin
        out_valid_o <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      addr_q <= address_i;
      wr_q   <= is_write_i;
    end
    if (upd_fire) begin
      hit_o             <= hit_q;
      fill_valid_o      <= !hit_q;
      fill_address_o    <= hit_q ? '0 : addr_q;
      writeback_valid_o <= !hit_q && meta.valid[victim] && meta.dirty[victim];
      if (!hit_q && meta.valid[victim] && meta.dirty[victim]) begin
        writeback_address_o <= {victim_tag, req_set, {OFS_BITS{1'b0}}};
      end else begin
        writeback_address_o <= '0;
      end
    end
  end

  // The counters only change when a new result is loaded, so they track the word.
  assign hits_so_far_o   = hits_q;
  assign misses_so_far_o = misses_q;

endmodule

>>> hw/rtl/slc_meta_store.sv
// Per-set metadata memory (valid, dirty, recency ranks) with one init bit per set.
// Depends on slc_pkg.
module slc_meta_store
  import slc_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      rd_en_i,
  input  set_idx_t  rd_set_i,
  input  meta_wr_t  wr_i,
  output set_meta_t meta_o
);

  set_meta_t           mem_q [SETS];
  logic [SETS-1:0]     init_q;
  set_meta_t           rdata_q;
  logic                rd_init_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      init_q    <= '0;
      rd_init_q <= 1'b0;
    end else begin
      if (wr_i.en) begin
        init_q[wr_i.set] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_init_q <= init_q[rd_set_i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_i.set] <= wr_i.meta;
    end
    if (rd_en_i) begin
      rdata_q <= mem_q[rd_set_i];
    end
  end

  // A set that was never written reads as its reset value.
  assign meta_o = rd_init_q ? rdata_q : reset_meta();

endmodule

>>> hw/rtl/slc_tag_scan.sv
// Tag memory and the shared tag comparator, stepped over the ways of one set.
// Depends on slc_pkg.
module slc_tag_scan
  import slc_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  scan_ctrl_t      ctrl_i,
  input  logic [WAYS-1:0] valid_i,
  input  tag_wr_t         wr_i,
  input  way_t            sel_way_i,
  output scan_stat_t      stat_o,
  output tag_t            sel_tag_o
);

  tag_t     mem_q [SETS*WAYS];
  tag_t     rdata_q;
  tag_t     seen_q [WAYS];
  way_t     way_q;
  set_idx_t set_q;
  tag_t     tag_q;

  way_t     rd_way;
  set_idx_t rd_set;
  logic     rd_en;

  always_comb begin
    rd_en  = ctrl_i.start || ctrl_i.advance;
    rd_set = ctrl_i.start ? ctrl_i.set : set_q;
    rd_way = ctrl_i.start ? '0 : WAY_BITS'(way_q + WAY_BITS'(1));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      way_q <= '0;
      set_q <= '0;
      tag_q <= '0;
    end else if (ctrl_i.start) begin
      way_q <= '0;
      set_q <= ctrl_i.set;
      tag_q <= ctrl_i.tag;
    end else if (ctrl_i.advance) begin
      way_q <= rd_way;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[{wr_i.set, wr_i.way}] <= wr_i.tag;
    end
    if (rd_en) begin
      rdata_q <= mem_q[{rd_set, rd_way}];
    end
    if (ctrl_i.scan) begin
      seen_q[way_q] <= rdata_q;
    end
  end

  // Tags of invalid ways are never trusted; the valid bit gates the compare.
  assign stat_o.match = valid_i[way_q] && (rdata_q == tag_q);
  assign stat_o.last  = (way_q == WAY_BITS'(WAYS - 1));
  assign stat_o.way   = way_q;
  assign sel_tag_o    = seen_q[sel_way_i];

endmodule

>>> verif/set_assoc_lru_writeback_cache_tb.sv
// Testbench for set_assoc_lru_writeback_cache: directed and random request words,
// checked against a tag, valid, dirty and LRU-rank predictor kept here.
// Depends on slc_pkg and the cache RTL only.
`timescale 1ns / 100ps

module set_assoc_lru_writeback_cache_tb;
  import slc_pkg::*;

  localparam int unsigned STALL_LIMIT = 4000;
  localparam int unsigned DRAIN_CYCLES = 24;

  typedef struct packed {
    logic   hit;
    logic   fill_valid;
    addr_t  fill_address;
    logic   wb_valid;
    addr_t  wb_address;
    count_t hits;
    count_t misses;
  } lookup_result_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 in_valid_i = 1'b0;
  logic                 in_ready_o;
  logic [ADDR_BITS-1:0] address_i = '0;
  logic                 is_write_i = 1'b0;
  logic                 out_valid_o;
  logic                 out_ready_i = 1'b0;
  logic                 hit_o;
  logic                 fill_valid_o;
  logic [ADDR_BITS-1:0] fill_address_o;
  logic                 writeback_valid_o;
  logic [ADDR_BITS-1:0] writeback_address_o;
  logic [CNT_BITS-1:0]  hits_so_far_o;
  logic [CNT_BITS-1:0]  misses_so_far_o;

  // Predicted cache state.
  tag_t   line_tag   [SETS][WAYS];
  logic   line_valid [SETS][WAYS];
  logic   line_dirty [SETS][WAYS];
  way_t   line_rank  [SETS][WAYS];
  count_t hit_total;
  count_t miss_total;

  lookup_result_t pending_results[$];
  int unsigned    errors = 0;
  bit             steady = 1'b0;

  set_assoc_lru_writeback_cache dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .address_i          (address_i),
    .is_write_i         (is_write_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .hit_o              (hit_o),
    .fill_valid_o       (fill_valid_o),
    .fill_address_o     (fill_address_o),
    .writeback_valid_o  (writeback_valid_o),
    .writeback_address_o(writeback_address_o),
    .hits_so_far_o      (hits_so_far_o),
    .misses_so_far_o    (misses_so_far_o)
  );

  always #6 clk_i = ~clk_i;

  always @(negedge clk_i) begin
    out_ready_i <= steady || ($urandom_range(99) >= 26);
  end

  function automatic addr_t make_addr(tag_t t, set_idx_t s, logic [OFS_BITS-1:0] o);
    return {t, s, o};
  endfunction

  task automatic clear_cache_model();
    for (int s = 0; s < int'(SETS); s++) begin
      for (int w = 0; w < int'(WAYS); w++) begin
        line_tag[s][w]   = '0;
        line_valid[s][w] = 1'b0;
        line_dirty[s][w] = 1'b0;
        line_rank[s][w]  = way_t'(w);
      end
    end
    hit_total  = '0;
    miss_total = '0;
  endtask

  // Looks the request up, updates the predicted state and returns the result word.
  function automatic lookup_result_t predict_lookup(addr_t a, logic wr);
    lookup_result_t r;
    set_idx_t       s;
    tag_t           t;
    int             victim;
    way_t           old_rank;
    r = '0;
    s = a[OFS_BITS +: IDX_BITS];
    t = a[OFS_BITS + IDX_BITS +: TAG_BITS];
    victim = -1;
    for (int w = 0; w < int'(WAYS); w++) begin
      if (victim < 0 && line_valid[s][w] && line_tag[s][w] == t) victim = w;
    end
    if (victim >= 0) begin
      if (hit_total != '1) hit_total++;
      r.hit = 1'b1;
      if (wr) line_dirty[s][victim] = 1'b1;
    end else begin
      if (miss_total != '1) miss_total++;
      for (int w = 0; w < int'(WAYS); w++) begin
        if (victim < 0 && !line_valid[s][w]) victim = w;
      end
      if (victim < 0) begin
        victim = 0;
        for (int w = 1; w < int'(WAYS); w++) begin
          if (line_rank[s][w] < line_rank[s][victim]) victim = w;
        end
      end
      r.fill_valid   = 1'b1;
      r.fill_address = a;
      if (line_valid[s][victim] && line_dirty[s][victim]) begin
        r.wb_valid   = 1'b1;
        r.wb_address = make_addr(line_tag[s][victim], s, '0);
      end
      line_tag[s][victim]   = t;
      line_valid[s][victim] = 1'b1;
      line_dirty[s][victim] = wr;
    end
    // The touched way becomes most recent; the ones above it move down one place.
    old_rank = line_rank[s][victim];
    for (int w = 0; w < int'(WAYS); w++) begin
      if (line_rank[s][w] > old_rank) line_rank[s][w]--;
    end
    line_rank[s][victim] = way_t'(WAYS - 1);
    r.hits   = hit_total;
    r.misses = miss_total;
    return r;
  endfunction

  task automatic send_request(addr_t a, logic wr);
    while (!steady && $urandom_range(99) < 26) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
    end
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    address_i  <= a;
    is_write_i <= wr;
    do @(posedge clk_i); while (!in_ready_o);
    pending_results.push_back(predict_lookup(a, wr));
  endtask

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t ns: %s expected %0h, got %0h", $time, name, want, got);
    end
  endtask

  always @(posedge clk_i) begin
    lookup_result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t ns: result word with no request pending, expected none, got hit=%0b",
                 $time, hit_o);
      end else begin
        want = pending_results.pop_front();
        check_field("hit", 32'(want.hit), 32'(hit_o));
        check_field("fill_valid", 32'(want.fill_valid), 32'(fill_valid_o));
        check_field("fill_address", 32'(want.fill_address), 32'(fill_address_o));
        check_field("writeback_valid", 32'(want.wb_valid), 32'(writeback_valid_o));
        check_field("writeback_address", 32'(want.wb_address), 32'(writeback_address_o));
        check_field("hits_so_far", want.hits, hits_so_far_o);
        check_field("misses_so_far", want.misses, misses_so_far_o);
      end
    end
  end

  // Ends the run if neither channel moves a word for too long.
  initial begin
    int unsigned stalled;
    stalled = 0;
    while (stalled < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) stalled = 0;
      else stalled++;
    end
    $display("TEST FAILED");
    $finish;
  end

  // Cold misses at both ends of the address range, then hits on the same lines.
  task automatic test_cold_misses();
    send_request(30'h0000_0000, 1'b0);
    send_request(30'h3FFF_FFFF, 1'b1);
    send_request(30'h0000_0010, 1'b0);
    send_request(30'h3FFF_FFC0, 1'b0);
    send_request(30'h3FFF_FFFF, 1'b1);
  endtask

  // Set 0 fills up; the least recent way holds tag zero and is dirty, so it is
  // written back. Later victims were filled by reads and leave without writeback.
  task automatic test_lru_eviction();
    send_request(make_addr('0, '0, 6'h3F), 1'b1);
    for (int t = 1; t <= 3; t++) send_request(make_addr(tag_t'(t), '0, '0), 1'b0);
    send_request(make_addr(tag_t'(4), '0, 6'h04), 1'b0);
    send_request(make_addr(tag_t'(1), '0, '0), 1'b0);
    send_request(make_addr(tag_t'(5), '0, '0), 1'b1);
    send_request(make_addr(tag_t'(6), '0, '0), 1'b0);
    send_request(make_addr(tag_t'(7), '0, 6'h20), 1'b0);
  endtask

  // Set 127 holds the all-ones tag dirty; filling the set pushes it out, which
  // gives the highest writeback address.
  task automatic test_top_line_writeback();
    for (int t = 1; t <= 4; t++) begin
      send_request(make_addr(tag_t'('1) - tag_t'(t), '1, '0), 1'b1);
    end
  endtask

  // Mostly a few hot sets and tags so that hits, dirty lines and evictions are
  // frequent; the rest are full-range random addresses.
  task automatic run_hot_sets(int unsigned n_items, int unsigned n_sets);
    set_idx_t hot_sets[4];
    tag_t     hot_tags[6];
    addr_t    a;
    for (int unsigned i = 0; i < n_items; i++) begin
      if (i % 48 == 0) begin
        foreach (hot_sets[k]) hot_sets[k] = set_idx_t'($urandom);
        foreach (hot_tags[k]) hot_tags[k] = tag_t'($urandom);
        if ($urandom_range(3) == 0) hot_tags[0] = '0;
        if ($urandom_range(3) == 0) hot_tags[1] = '1;
      end
      if ($urandom_range(99) < 80) begin
        a = make_addr(hot_tags[$urandom_range(5)], hot_sets[$urandom_range(n_sets - 1)],
                      OFS_BITS'($urandom));
      end else begin
        a = addr_t'($urandom);
      end
      send_request(a, 1'($urandom_range(1)));
    end
  endtask

  task automatic test_random_traffic();
    run_hot_sets(880, 4);
  endtask

  // No idling on either side, and only two hot sets, so back-to-back words often
  // land in the same set.
  task automatic test_back_to_back();
    steady = 1'b1;
    run_hot_sets(220, 2);
    steady = 1'b0;
  endtask

  initial begin
    clear_cache_model();
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_cold_misses();
    test_lru_eviction();
    test_top_line_writeback();
    test_random_traffic();
    test_back_to_back();

    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (errors == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule
